// File: hw/rtl/bds_pkg.sv
// Shared types and codes of the bounded deduplicating set.
`default_nettype none

package bds_pkg;

  // Request operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Result status codes.
  localparam logic [2:0] ST_CAP_SET   = 3'd0;
  localparam logic [2:0] ST_INSERTED  = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_BAD_CAP   = 3'd4;
  localparam logic [2:0] ST_ELEMENT   = 3'd5;
  localparam logic [2:0] ST_EMPTY     = 3'd6;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ
  } bds_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/bounded_dedup_set_top.sv
// Bounded deduplicating set: one entry memory walked by a small sequencer.
// Capacity, full, bad-capacity and first-insert writes give a registered result in the
// cycle after acceptance and the next request may follow at once. Other inserts walk the
// stored entries through the registered memory read port.
// A read-out gives fill_count results on consecutive cycles, the first after the state,
// read-data and output registers; a read-out of an empty set gives one empty status.
// Synchronous active-low reset clears the control state; the entry memory is not cleared.
`default_nettype none

module bounded_dedup_set_top
  import bds_pkg::*;
#(
  parameter int MAX_ENTRIES = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_opcode,
  input  wire logic signed [31:0] in_value,
  input  wire logic        [21:0] in_owner_id,
  output logic                    out_valid,
  output logic             [2:0]  out_status,
  output logic signed      [31:0] out_element,
  output logic                    out_last
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [31:0] MAX_VAL = 32'(MAX_ENTRIES);

  // Control and payload registers.
  bds_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [CNT_W-1:0]   cap_r, cap_nxt;
  logic [21:0]        owner_r, owner_nxt;
  logic [31:0]        value_r, value_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic               issue_done_r, issue_done_nxt;
  logic               rvld_r, rlast_r;
  logic [31:0]        rdata_r;
  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         out_status_r, out_status_nxt;
  logic [31:0]        out_element_r, out_element_nxt;
  logic               out_last_r, out_last_nxt;

  // Memory controls.
  logic               mem_we;
  logic [31:0]        mem_wdata;
  logic               issue;
  logic               rd_last;
  logic               owner_clr;
  logic               cap_ok;

  logic [31:0] mem [MAX_ENTRIES];

  // A write request from another owner on a configured set clears it first.
  assign owner_clr = (cap_r != '0) && (owner_r != in_owner_id);
  assign cap_ok    = !in_value[31] && (in_value != '0) && ($unsigned(in_value) <= MAX_VAL);
  assign rd_last   = (CNT_W'(rd_idx_r) == (fill_r - CNT_W'(1)));

  // Next state, memory controls and result generation.
  always_comb begin
    state_nxt       = state_r;
    fill_nxt        = fill_r;
    cap_nxt         = cap_r;
    owner_nxt       = owner_r;
    value_nxt       = value_r;
    rd_idx_nxt      = rd_idx_r;
    issue_done_nxt  = issue_done_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = ST_CAP_SET;
    out_element_nxt = '0;
    out_last_nxt    = 1'b1;
    mem_we          = 1'b0;
    mem_wdata       = value_r;
    issue           = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          value_nxt      = in_value;
          rd_idx_nxt     = '0;
          issue_done_nxt = 1'b0;
          mem_wdata      = in_value;
          if (in_opcode == OP_WRITE) begin
            out_valid_nxt = 1'b1;
            if (owner_clr) begin
              cap_nxt   = '0;
              fill_nxt  = '0;
              owner_nxt = in_owner_id;
            end
            if ((cap_r == '0) || owner_clr) begin
              if (cap_ok) begin
                cap_nxt        = in_value[CNT_W-1:0];
                fill_nxt       = '0;
                owner_nxt      = in_owner_id;
                out_status_nxt = ST_CAP_SET;
              end else begin
                out_status_nxt = ST_BAD_CAP;
              end
            end else if (fill_r >= cap_r) begin
              out_status_nxt = ST_FULL;
            end else if (fill_r == '0) begin
              // Nothing to compare against: append at once.
              mem_we         = 1'b1;
              fill_nxt       = fill_r + CNT_W'(1);
              out_status_nxt = ST_INSERTED;
            end else begin
              out_valid_nxt = 1'b0;
              state_nxt     = S_SCAN;
            end
          end else begin
            if (fill_r == '0) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_EMPTY;
            end else begin
              state_nxt = S_READ;
            end
          end
        end
      end

      S_SCAN: begin
        issue = !issue_done_r;
        if (issue) begin
          rd_idx_nxt = rd_idx_r + IDX_W'(1);
          if (rd_last) begin
            issue_done_nxt = 1'b1;
          end
        end
        if (rvld_r) begin
          if (rdata_r == value_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_DUPLICATE;
            state_nxt      = S_IDLE;
          end else if (rlast_r) begin
            // No match in the whole set: append behind the last entry.
            mem_we         = 1'b1;
            fill_nxt       = fill_r + CNT_W'(1);
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_INSERTED;
            state_nxt      = S_IDLE;
          end
        end
      end

      S_READ: begin
        issue = !issue_done_r;
        if (issue) begin
          rd_idx_nxt = rd_idx_r + IDX_W'(1);
          if (rd_last) begin
            issue_done_nxt = 1'b1;
          end
        end
        if (rvld_r) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = ST_ELEMENT;
          out_element_nxt = rdata_r;
          out_last_nxt    = rlast_r;
          if (rlast_r) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r       <= '0;
      cap_r        <= '0;
      owner_r      <= '0;
      issue_done_r <= 1'b0;
      rvld_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      fill_r       <= fill_nxt;
      cap_r        <= cap_nxt;
      owner_r      <= owner_nxt;
      issue_done_r <= issue_done_nxt;
      rvld_r       <= issue;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    value_r       <= value_nxt;
    rd_idx_r      <= rd_idx_nxt;
    rlast_r       <= issue && rd_last;
    out_status_r  <= out_status_nxt;
    out_element_r <= out_element_nxt;
    out_last_r    <= out_last_nxt;
  end

  // Entry memory. Writes land only while the sequencer is idle or returns to it, and a walk
  // issues its reads only after it has left idle, so reads never overlap a write.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[fill_r[IDX_W-1:0]] <= mem_wdata;
    end
    rdata_r <= mem[rd_idx_r];
  end

  assign busy        = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_element = out_element_r;
  assign out_last    = out_last_r;

endmodule

`default_nettype wire

// File: hw/rtl/bds_chk.sv
// Port-level checker for the bounded deduplicating set, with its bind statement.
`default_nettype none

module bds_chk
  import bds_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [2:0]  out_status,
  input wire logic [31:0] out_element,
  input wire logic        out_last
);

  // Every result that is not a stored element closes its request.
  a_single_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_ELEMENT) |-> out_last)
    else $error("non-element result without last flag");

  // Only read-out results carry an element value.
  a_zero_element : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_ELEMENT) |-> (out_element == '0))
    else $error("non-element result with non-zero element");

  // Once the final result is shown the block is ready for a new request.
  a_last_idle : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy)
    else $error("busy while final result is shown");

  // An accepted request either answers at once or keeps the block busy.
  a_accept_progress : assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted request neither answered nor in progress");

  // A read-out streams its elements on consecutive cycles.
  a_stream : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid && (out_status == ST_ELEMENT))
    else $error("gap in element read-out");

endmodule

bind bounded_dedup_set_top bds_chk u_bds_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .out_valid   (out_valid),
  .out_status  (out_status),
  .out_element (out_element),
  .out_last    (out_last)
);

`default_nettype wire
